[src/iacp_pkg.sv]
// Shared constants, types and helpers for the inverse Albers conic block.
// Used by iacp_unit, iacp_mul and the top level; depends on nothing else.
package iacp_pkg;

   // Refinement bound and width of its counter
   localparam int MAX_ITER = 8;
   localparam int ITER_W   = $clog2(MAX_ITER);

   // Projection constants in fixed point
   localparam logic signed [33:0] RHOBAS_Q8 = 34'sd2541844367;
   localparam logic [61:0]        ROSQ_Q8   = 62'd38654917579132928;
   localparam logic [61:0]        TBBON_Q8  = 62'd34313870582839296;
   localparam logic [32:0]        ECC_Q32   = 33'd353354923;
   localparam logic [38:0]        INV_AEN   = 39'd408163991337;
   localparam logic [38:0]        INV_RPD   = 39'd246083499208;
   localparam logic [32:0]        TOL_K     = 33'd550;
   localparam logic signed [32:0] LON96     = 33'sd1610612736;
   localparam logic [31:0]        LAT90     = 32'd1509949440;
   localparam logic [32:0]        ONE_Q32   = 33'h1_0000_0000;

   // Series coefficients 2/3, 3/5, 4/7, 5/9, 6/11, 7/13, 8/15 in Q.32
   localparam logic [32:0] COEF [0:6] = '{
      33'd2863311531, 33'd2576980378, 33'd2454267026, 33'd2386092942,
      33'd2342709434, 33'd2312674698, 33'd2290649225
   };

   // atan(2^-i) in Q.32 for the first eleven steps
   localparam logic signed [35:0] ATAN_TAB [0:10] = '{
      36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
      36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
      36'sd16777131,   36'sd8388597,    36'sd4194303
   };

   // Operation of the shared shift-add unit
   typedef enum logic [1:0] {
      UM_CORDIC,
      UM_DIV,
      UM_SQRT
   } unit_mode_type;

   typedef struct packed {
      logic          start;
      unit_mode_type mode;
      logic [63:0]   op_a;
      logic [63:0]   op_b;
   } unit_cmd_type;

   typedef struct packed {
      logic        done;
      logic [35:0] result;
   } unit_sts_type;

   // Angle added at CORDIC step i
   function automatic logic signed [35:0] step_angle(input logic [4:0] i);
      logic [5:0] sh;
      sh = 6'd32 - {1'b0, i};
      if (i < 5'd11) begin
         return ATAN_TAB[i[3:0]];
      end
      return $signed(36'd1 << sh);
   endfunction

endpackage

[src/iacp_mul.sv]
// Registered 33 x 33 unsigned multiplier shared by every product step.
// Depends on iacp_pkg for nothing but house convention.
module iacp_mul
   import iacp_pkg::*;
(
   input  logic        clock,
   input  logic [32:0] mul_a,
   input  logic [32:0] mul_b,
   output logic [65:0] mul_p
);

   logic [65:0] p_ff;
   logic [65:0] p_in;

   // Form the full product
   assign p_in  = 66'(mul_a) * 66'(mul_b);
   assign mul_p = p_ff;

   // Register the product for the next state
   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

[src/iacp_unit.sv]
// Shared 32-step shift-add unit: CORDIC vectoring, restoring divide, integer sqrt.
// Depends on iacp_pkg for the command and status structs and the angle table.
module iacp_unit
   import iacp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  unit_cmd_type cmd,
   output unit_sts_type sts
);

   unit_mode_type mode_ff, mode_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [64:0]   ra_ff, ra_in;
   logic [64:0]   rb_ff, rb_in;
   logic [35:0]   rc_ff, rc_in;
   logic          sat_ff, sat_in;

   // CORDIC step
   logic signed [51:0] cx, cy, cdx, cdy;
   logic signed [35:0] cz, cang;
   // Divide step
   logic [57:0] dr2, dbv;
   // Square root step
   logic [5:0]  sq_sh;
   logic [63:0] sq_bit;
   logic [64:0] sq_sum, sq_v;

   assign cx   = $signed(ra_ff[51:0]);
   assign cy   = $signed(rb_ff[51:0]);
   assign cz   = $signed(rc_ff);
   assign cdx  = cy >>> cnt_ff;
   assign cdy  = cx >>> cnt_ff;
   assign cang = step_angle(cnt_ff);

   assign dr2 = {ra_ff[56:0], 1'b0};
   assign dbv = rb_ff[57:0];

   assign sq_sh  = 6'd62 - {cnt_ff, 1'b0};
   assign sq_bit = 64'd1 << sq_sh;
   assign sq_sum = {1'b0, rb_ff[63:0]} + {1'b0, sq_bit};
   assign sq_v   = {1'b0, ra_ff[63:0]};

   // Load on start, then advance one step a cycle
   always_comb begin
      mode_in = mode_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      rc_in   = rc_ff;
      sat_in  = sat_ff;
      if (cmd.start) begin
         mode_in = cmd.mode;
         run_in  = 1'b1;
         cnt_in  = 5'd0;
         ra_in   = {1'b0, cmd.op_a};
         rb_in   = (cmd.mode == UM_SQRT) ? 65'd0 : {1'b0, cmd.op_b};
         rc_in   = 36'd0;
         sat_in  = cmd.op_a >= cmd.op_b;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
         case (mode_ff)
            UM_CORDIC: begin
               if (!cy[51]) begin
                  ra_in = {13'd0, $unsigned(cx + cdx)};
                  rb_in = {13'd0, $unsigned(cy - cdy)};
                  rc_in = $unsigned(cz + cang);
               end else begin
                  ra_in = {13'd0, $unsigned(cx - cdx)};
                  rb_in = {13'd0, $unsigned(cy + cdy)};
                  rc_in = $unsigned(cz - cang);
               end
            end
            UM_DIV: begin
               if (dr2 >= dbv) begin
                  ra_in = {7'd0, dr2 - dbv};
                  rc_in = {rc_ff[34:0], 1'b1};
               end else begin
                  ra_in = {7'd0, dr2};
                  rc_in = {rc_ff[34:0], 1'b0};
               end
            end
            UM_SQRT: begin
               if (sq_v >= sq_sum) begin
                  ra_in = sq_v - sq_sum;
                  rb_in = {1'b0, (rb_ff[63:0] >> 1) + sq_bit};
               end else begin
                  rb_in = {1'b0, rb_ff[63:0] >> 1};
               end
            end
            default: begin
               run_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= UM_CORDIC;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
      end
      cnt_ff <= cnt_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      rc_ff  <= rc_in;
      sat_ff <= sat_in;
   end

   // Select the result of the finished operation
   always_comb begin
      sts.done = done_ff;
      case (mode_ff)
         UM_CORDIC: sts.result = rc_ff;
         UM_DIV:    sts.result = sat_ff ? 36'(ONE_Q32) : rc_ff;
         UM_SQRT:   sts.result = rb_ff[35:0];
         default:   sts.result = 36'd0;
      endcase
   end

endmodule

[src/inverse_albers_conic_projection_top.sv]
// Top level of the inverse Albers conic block: sequencer and result register.
// Depends on iacp_pkg, iacp_mul and iacp_unit.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_northing, req_easting
//   rsp      out        rsp_valid/rsp_stall  rsp_lat_deg, rsp_lon_deg,
//                                            rsp_domain_error, rsp_not_converged
//
// One item at a time. An item takes 1 to MAX_ITER series refinements and uses the
// shared shift-add unit for two CORDICs, two square roots, the numerator divide and
// one divide per refinement. Zero easting skips the first CORDIC, a zero or unit sine
// skips a square root, and a domain error skips everything after the squared radius.
// Synchronous active-high reset clears the sequencer and the result valid.
// req_stall is high while an item is in work; a stalled result holds and a
// finished item waits in its last state until the result register frees up.
module inverse_albers_conic_projection_top
   import iacp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_northing,
   input  logic signed [31:0] req_easting,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_lat_deg,
   output logic signed [32:0] rsp_lon_deg,
   output logic               rsp_domain_error,
   output logic               rsp_not_converged
);

   typedef enum logic [24:0] {
      ST_IDLE   = 25'd1,
      ST_LON_ST = 25'd2,
      ST_LON_W  = 25'd4,
      ST_MS1    = 25'd8,
      ST_MS2    = 25'd16,
      ST_MS3    = 25'd32,
      ST_RSQ1   = 25'd64,
      ST_RSQ2   = 25'd128,
      ST_RSQ3   = 25'd256,
      ST_NUM_W  = 25'd512,
      ST_COSA   = 25'd1024,
      ST_COSB   = 25'd2048,
      ST_COSW   = 25'd4096,
      ST_TOL1   = 25'd8192,
      ST_TOL2   = 25'd16384,
      ST_IT_X   = 25'd32768,
      ST_IT_XX  = 25'd65536,
      ST_IT_XX2 = 25'd131072,
      ST_IT_AM  = 25'd262144,
      ST_IT_AA  = 25'd524288,
      ST_IT_DIV = 25'd1048576,
      ST_IT_DW  = 25'd2097152,
      ST_LATC   = 25'd4194304,
      ST_LAT_W  = 25'd8388608,
      ST_OUT    = 25'd16777216
   } state_type;

   state_type          state_ff, state_in;
   logic [32:0]        d_ff, d_in;
   logic signed [31:0] e_ff, e_in;
   logic signed [32:0] lon_ff, lon_in;
   logic               zneg_ff, zneg_in;
   logic [32:0]        mag_ff, mag_in;
   logic               which_ff, which_in;
   logic [71:0]        acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic               dom_ff, dom_in;
   logic [31:0]        latmag_ff, latmag_in;
   logic [32:0]        num_ff, num_in;
   logic [32:0]        s_ff, s_in;
   logic [32:0]        cos_ff, cos_in;
   logic               cret_ff, cret_in;
   logic [1:0]         tol_ff, tol_in;
   logic [25:0]        xx_ff, xx_in;
   logic [33:0]        ser_ff, ser_in;
   logic [2:0]         term_ff, term_in;
   logic [ITER_W-1:0]  it_ff, it_in;
   logic               nconv_ff, nconv_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_lat_ff, rsp_lat_in;
   logic signed [32:0] rsp_lon_ff, rsp_lon_in;
   logic               rsp_dom_ff, rsp_dom_in;
   logic               rsp_nconv_ff, rsp_nconv_in;

   unit_cmd_type cmd;
   unit_sts_type sts;
   logic [32:0]  mul_a, mul_b;
   logic [65:0]  mul_p;

   logic signed [33:0] d_calc;
   logic [31:0]        e_abs;
   logic [33:0]        d_rnd;
   logic [32:0]        e_rnd;
   logic [61:0]        rsq, diff;
   logic               rsq_neg;
   logic signed [35:0] zres, zabs;
   logic [38:0]        inv_sel;
   logic [71:0]        msum;
   logic [31:0]        ang;
   logic [32:0]        ser_add;
   logic [32:0]        q_new, dlt;

   iacp_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   iacp_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   // Datapath helpers
   assign d_calc  = RHOBAS_Q8 - 34'(req_northing);
   assign e_abs   = e_ff[31] ? (~$unsigned(e_ff) + 32'd1) : $unsigned(e_ff);
   assign d_rnd   = {1'b0, d_ff} + 34'd8;
   assign e_rnd   = {1'b0, e_abs} + 33'd8;
   assign rsq     = acc_ff[61:0] + mul_p[61:0];
   assign rsq_neg = rsq > ROSQ_Q8;
   assign diff    = rsq_neg ? (rsq - ROSQ_Q8) : (ROSQ_Q8 - rsq);
   assign zres    = $signed(sts.result);
   assign zabs    = zres[35] ? -zres : zres;
   assign inv_sel = which_ff ? INV_RPD : INV_AEN;
   assign msum    = acc_ff + {mul_p[39:0], 32'd0};
   assign ang     = msum[71:40];
   assign ser_add = (term_ff == 3'd0) ? ONE_Q32 : COEF[term_ff - 3'd1];
   assign q_new   = sts.result[32:0];
   assign dlt     = (q_new > s_ff) ? (q_new - s_ff) : (s_ff - q_new);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      lon_in       = lon_ff;
      zneg_in      = zneg_ff;
      mag_in       = mag_ff;
      which_in     = which_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      dom_in       = dom_ff;
      latmag_in    = latmag_ff;
      num_in       = num_ff;
      s_in         = s_ff;
      cos_in       = cos_ff;
      cret_in      = cret_ff;
      tol_in       = tol_ff;
      xx_in        = xx_ff;
      ser_in       = ser_ff;
      term_in      = term_ff;
      it_in        = it_ff;
      nconv_in     = nconv_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_lat_in   = rsp_lat_ff;
      rsp_lon_in   = rsp_lon_ff;
      rsp_dom_in   = rsp_dom_ff;
      rsp_nconv_in = rsp_nconv_ff;
      cmd.start    = 1'b0;
      cmd.mode     = UM_CORDIC;
      cmd.op_a     = 64'd0;
      cmd.op_b     = 64'd0;
      mul_a        = 33'd0;
      mul_b        = 33'd0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               d_in     = d_calc[32:0];
               e_in     = req_easting;
               dom_in   = 1'b0;
               nconv_in = 1'b0;
               state_in = ST_LON_ST;
            end
         end
         // Polar angle, or the central meridian for zero easting
         ST_LON_ST: begin
            if (e_ff == 32'sd0) begin
               lon_in   = LON96;
               state_in = ST_RSQ1;
            end else begin
               cmd.start = 1'b1;
               cmd.mode  = UM_CORDIC;
               cmd.op_a  = {15'd0, d_ff, 16'd0};
               cmd.op_b  = {{16{e_ff[31]}}, e_ff, 16'd0};
               state_in  = ST_LON_W;
            end
         end
         ST_LON_W: begin
            if (sts.done) begin
               zneg_in  = zres[35];
               mag_in   = zabs[32:0];
               which_in = 1'b0;
               state_in = ST_MS1;
            end
         end
         // Radians to degrees: two partial products, then shift down by 40
         ST_MS1: begin
            mul_a    = mag_ff;
            mul_b    = {1'b0, inv_sel[31:0]};
            state_in = ST_MS2;
         end
         ST_MS2: begin
            acc_in   = 72'(mul_p);
            mul_a    = mag_ff;
            mul_b    = 33'(inv_sel[38:32]);
            state_in = ST_MS3;
         end
         ST_MS3: begin
            if (!which_ff) begin
               lon_in   = zneg_ff ? (LON96 + $signed({1'b0, ang}))
                                  : (LON96 - $signed({1'b0, ang}));
               state_in = ST_RSQ1;
            end else begin
               latmag_in = (ang > LAT90) ? LAT90 : ang;
               state_in  = ST_OUT;
            end
         end
         // Squared radius from rounded Q.4 terms
         ST_RSQ1: begin
            mul_a    = 33'(d_rnd[33:4]);
            mul_b    = 33'(d_rnd[33:4]);
            state_in = ST_RSQ2;
         end
         ST_RSQ2: begin
            acc_in   = 72'(mul_p);
            mul_a    = 33'(e_rnd[32:4]);
            mul_b    = 33'(e_rnd[32:4]);
            state_in = ST_RSQ3;
         end
         ST_RSQ3: begin
            neg_in = rsq_neg;
            if (diff > TBBON_Q8) begin
               dom_in    = 1'b1;
               latmag_in = LAT90;
               state_in  = ST_OUT;
            end else begin
               cmd.start = 1'b1;
               cmd.mode  = UM_DIV;
               cmd.op_a  = 64'(diff);
               cmd.op_b  = 64'(TBBON_Q8);
               state_in  = ST_NUM_W;
            end
         end
         ST_NUM_W: begin
            if (sts.done) begin
               num_in   = q_new;
               s_in     = q_new;
               cret_in  = 1'b0;
               state_in = ST_COSA;
            end
         end
         // sqrt(1 - s^2), then return to tolerance or latitude
         ST_COSA: begin
            if (s_ff == 33'd0) begin
               cos_in   = ONE_Q32;
               state_in = cret_ff ? ST_LATC : ST_TOL1;
            end else if (s_ff[32]) begin
               cos_in   = 33'd0;
               state_in = cret_ff ? ST_LATC : ST_TOL1;
            end else begin
               mul_a    = s_ff;
               mul_b    = s_ff;
               state_in = ST_COSB;
            end
         end
         ST_COSB: begin
            cmd.start = 1'b1;
            cmd.mode  = UM_SQRT;
            cmd.op_a  = 64'd0 - mul_p[63:0];
            state_in  = ST_COSW;
         end
         ST_COSW: begin
            if (sts.done) begin
               cos_in   = q_new;
               state_in = cret_ff ? ST_LATC : ST_TOL1;
            end
         end
         ST_TOL1: begin
            mul_a    = TOL_K;
            mul_b    = cos_ff;
            state_in = ST_TOL2;
         end
         ST_TOL2: begin
            tol_in   = mul_p[41:40];
            it_in    = '0;
            state_in = ST_IT_X;
         end
         // One refinement: series in (e*s)^2, then divide
         ST_IT_X: begin
            mul_a    = s_ff;
            mul_b    = ECC_Q32;
            state_in = ST_IT_XX;
         end
         ST_IT_XX: begin
            mul_a    = 33'(mul_p[60:32]);
            mul_b    = 33'(mul_p[60:32]);
            state_in = ST_IT_XX2;
         end
         ST_IT_XX2: begin
            xx_in    = mul_p[57:32];
            ser_in   = 34'(COEF[6]);
            term_in  = 3'd6;
            state_in = ST_IT_AM;
         end
         ST_IT_AM: begin
            mul_a    = ser_ff[32:0];
            mul_b    = 33'(xx_ff);
            state_in = ST_IT_AA;
         end
         ST_IT_AA: begin
            ser_in = 34'(mul_p[58:32]) + 34'(ser_add);
            if (term_ff == 3'd0) begin
               state_in = ST_IT_DIV;
            end else begin
               term_in  = term_ff - 3'd1;
               state_in = ST_IT_AM;
            end
         end
         ST_IT_DIV: begin
            cmd.start = 1'b1;
            cmd.mode  = UM_DIV;
            cmd.op_a  = 64'(num_ff);
            cmd.op_b  = 64'(ser_ff);
            state_in  = ST_IT_DW;
         end
         ST_IT_DW: begin
            if (sts.done) begin
               s_in = q_new;
               if (dlt <= 33'(tol_ff)) begin
                  nconv_in = 1'b0;
                  cret_in  = 1'b1;
                  state_in = ST_COSA;
               end else if (it_ff == ITER_W'(MAX_ITER - 1)) begin
                  nconv_in = 1'b1;
                  cret_in  = 1'b1;
                  state_in = ST_COSA;
               end else begin
                  it_in    = it_ff + ITER_W'(1);
                  state_in = ST_IT_X;
               end
            end
         end
         // Arcsine as the angle of (cos, s)
         ST_LATC: begin
            cmd.start = 1'b1;
            cmd.mode  = UM_CORDIC;
            cmd.op_a  = {15'd0, cos_ff, 16'd0};
            cmd.op_b  = {15'd0, s_ff, 16'd0};
            state_in  = ST_LAT_W;
         end
         ST_LAT_W: begin
            if (sts.done) begin
               if (zres[35] || zres == 36'sd0) begin
                  latmag_in = 32'd0;
                  state_in  = ST_OUT;
               end else begin
                  mag_in   = zres[32:0];
                  which_in = 1'b1;
                  state_in = ST_MS1;
               end
            end
         end
         // Hold until the result register is free
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_lat_in   = neg_ff ? $signed(32'd0 - latmag_ff) : $signed(latmag_ff);
               rsp_lon_in   = lon_ff;
               rsp_dom_in   = dom_ff;
               rsp_nconv_in = nconv_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff         <= d_in;
      e_ff         <= e_in;
      lon_ff       <= lon_in;
      zneg_ff      <= zneg_in;
      mag_ff       <= mag_in;
      which_ff     <= which_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      dom_ff       <= dom_in;
      latmag_ff    <= latmag_in;
      num_ff       <= num_in;
      s_ff         <= s_in;
      cos_ff       <= cos_in;
      cret_ff      <= cret_in;
      tol_ff       <= tol_in;
      xx_ff        <= xx_in;
      ser_ff       <= ser_in;
      term_ff      <= term_in;
      it_ff        <= it_in;
      nconv_ff     <= nconv_in;
      rsp_lat_ff   <= rsp_lat_in;
      rsp_lon_ff   <= rsp_lon_in;
      rsp_dom_ff   <= rsp_dom_in;
      rsp_nconv_ff <= rsp_nconv_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lat_deg       = rsp_lat_ff;
   assign rsp_lon_deg       = rsp_lon_ff;
   assign rsp_domain_error  = rsp_dom_ff;
   assign rsp_not_converged = rsp_nconv_ff;

endmodule

[test/iacp_checker.sv]
`timescale 1ns / 1ps
// Checker for the inverse Albers conic block: predicts each point's result and
// compares it with what leaves the rsp channel. Uses only the port-level signals.
module iacp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_northing,
   input  logic signed [31:0] req_easting,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_lat_deg,
   input  logic signed [32:0] rsp_lon_deg,
   input  logic               rsp_domain_error,
   input  logic               rsp_not_converged,
   output int                 fail_count,
   output int                 open_points
);

   localparam int          REFINE_LIMIT = 8;
   localparam longint      BASE_RADIUS  = 64'sd2541844367;
   localparam logic [63:0] ORIGIN_SQ    = 64'd38654917579132928;
   localparam logic [63:0] SPAN_SQ      = 64'd34313870582839296;
   localparam logic [63:0] ECC          = 64'd353354923;
   localparam logic [63:0] RAD_TO_LON   = 64'd408163991337;
   localparam logic [63:0] RAD_TO_LAT   = 64'd246083499208;
   localparam logic [63:0] TOL_SCALE    = 64'd550;
   localparam longint      MERIDIAN_96  = 64'sd1610612736;
   localparam logic [63:0] RIGHT_ANGLE  = 64'd1509949440;
   localparam logic [63:0] UNIT         = 64'h1_0000_0000;

   localparam longint ARCTAN [0:10] = '{
      64'sd3373259426, 64'sd1991351318, 64'sd1052175346, 64'sd534100635,
      64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
      64'sd16777131, 64'sd8388597, 64'sd4194303
   };
   localparam logic [63:0] SERIES [0:6] = '{
      64'd2863311531, 64'd2576980378, 64'd2454267026, 64'd2386092942,
      64'd2342709434, 64'd2312674698, 64'd2290649225
   };

   typedef struct {
      logic signed [31:0] lat;
      logic signed [32:0] lon;
      logic               dom;
      logic               nconv;
   } geo_point_type;

   geo_point_type expected_points[$];

   // Angle of (x, y) with x >= 0, Q.32 radians, 32 vectoring steps
   function automatic longint vector_angle(longint x, longint y);
      longint z, dx, dy, a;
      z = 0;
      for (int i = 0; i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         a  = (i < 11) ? ARCTAN[i] : (64'sd1 <<< (32 - i));
         if (y >= 0) begin
            x += dx; y -= dy; z += a;
         end else begin
            x -= dx; y += dy; z -= a;
         end
      end
      return z;
   endfunction

   function automatic logic [63:0] scale_down(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[103:40];
   endfunction

   // floor(a * 2^32 / b) for a <= b
   function automatic logic [63:0] ratio_q32(logic [63:0] a, logic [63:0] b);
      logic [63:0] r, q;
      if (b == 0) return 0;
      if (a >= b) return UNIT;
      r = a;
      q = 0;
      for (int i = 0; i < 32; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= b) begin
            r -= b;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] cosine_of(logic [63:0] s);
      if (s == 0) return UNIT;
      if (s >= UNIT) return 0;
      return int_sqrt(64'd0 - s * s);
   endfunction

   // Geographic position of one projected point
   function automatic geo_point_type locate_point(logic signed [31:0] north,
                                                   logic signed [31:0] east);
      geo_point_type g;
      longint        radial, z, lon, ang_lat;
      logic [63:0]   ang, d4, e4, rsq, diff, latmag, num, tol, s, prev, x, xx, acc, dlt;
      logic          below, done;
      radial = BASE_RADIUS - longint'(north);
      g.dom = 0;
      g.nconv = 0;
      if (east == 0) begin
         lon = MERIDIAN_96;
      end else begin
         z   = vector_angle(radial * 65536, longint'(east) * 65536);
         ang = scale_down(z < 0 ? -z : z, RAD_TO_LON);
         lon = (z < 0) ? MERIDIAN_96 + longint'(ang) : MERIDIAN_96 - longint'(ang);
      end
      d4 = (radial + 8) >> 4;
      e4 = ((east < 0 ? -longint'(east) : longint'(east)) + 8) >> 4;
      rsq = d4 * d4 + e4 * e4;
      below = rsq > ORIGIN_SQ;
      diff = below ? rsq - ORIGIN_SQ : ORIGIN_SQ - rsq;
      if (diff > SPAN_SQ) begin
         g.dom = 1;
         latmag = RIGHT_ANGLE;
      end else begin
         num  = ratio_q32(diff, SPAN_SQ);
         tol  = (TOL_SCALE * cosine_of(num)) >> 40;
         s    = num;
         done = 0;
         for (int it = 0; it < REFINE_LIMIT && !done; it++) begin
            prev = s;
            x    = (s * ECC) >> 32;
            xx   = (x * x) >> 32;
            acc  = SERIES[6];
            for (int k = 5; k >= 0; k--) acc = ((acc * xx) >> 32) + SERIES[k];
            acc  = ((acc * xx) >> 32) + UNIT;
            s    = ratio_q32(num, acc);
            dlt  = (s > prev) ? s - prev : prev - s;
            if (dlt <= tol) done = 1;
         end
         g.nconv = !done;
         ang_lat = vector_angle(longint'(cosine_of(s)) * 65536, longint'(s) * 65536);
         latmag = (ang_lat <= 0) ? 0 : scale_down(ang_lat, RAD_TO_LAT);
         if (latmag > RIGHT_ANGLE) latmag = RIGHT_ANGLE;
      end
      g.lat = below ? -latmag[31:0] : latmag[31:0];
      g.lon = lon[32:0];
      return g;
   endfunction

   // Queue each accepted point, compare each accepted result with the oldest
   always @(posedge clock) begin
      geo_point_type want;
      if (reset) begin
         fail_count  <= 0;
         open_points <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_points.push_back(locate_point(req_northing, req_easting));
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("result with no point outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_points.pop_front();
               if (rsp_lat_deg !== want.lat || rsp_lon_deg !== want.lon ||
                   rsp_domain_error !== want.dom || rsp_not_converged !== want.nconv)
                  fail_count <= fail_count + 1;
               if (rsp_lat_deg !== want.lat)
                  $error("lat_deg expected %0d got %0d", want.lat, rsp_lat_deg);
               if (rsp_lon_deg !== want.lon)
                  $error("lon_deg expected %0d got %0d", want.lon, rsp_lon_deg);
               if (rsp_domain_error !== want.dom)
                  $error("domain_error expected %0d got %0d", want.dom, rsp_domain_error);
               if (rsp_not_converged !== want.nconv)
                  $error("not_converged expected %0d got %0d", want.nconv,
                         rsp_not_converged);
            end
         end
         open_points <= expected_points.size();
      end
   end

endmodule

[test/inverse_albers_conic_projection_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the inverse Albers conic block: clock, reset, point stimulus,
// result back-pressure and verdict. Depends on the block and on iacp_checker.
module inverse_albers_conic_projection_top_tb;

   localparam int RANDOM_POINTS = 1130;
   localparam int QUIET_POINTS  = 100;
   localparam int STALL_LIMIT   = 20000;
   localparam int DRAIN_CYCLES  = 800;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [31:0] req_northing = 0;
   logic signed [31:0] req_easting = 0;
   logic               rsp_valid;
   logic               rsp_stall = 1;
   logic signed [31:0] rsp_lat_deg;
   logic signed [32:0] rsp_lon_deg;
   logic               rsp_domain_error;
   logic               rsp_not_converged;
   logic               quiet = 0;
   int                 fail_count;
   int                 open_points;
   int                 idle_cycles = 0;

   inverse_albers_conic_projection_top uut (.*);

   iacp_checker u_checker (.*);

   always #5 clock = ~clock;

   // Send one point and hold it until accepted
   task automatic send_point(logic signed [31:0] n, logic signed [31:0] e);
      req_valid    <= 1;
      req_northing <= n;
      req_easting  <= e;
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 4))
         0, 1: return $urandom_range(0, 1536000000) - 768000000;
         2: return $urandom_range(0, 2000000) - 1000000;
         3: return 0;
         default: return $urandom;
      endcase
   endfunction

   // Result side: one long hold-off, then random stall bursts, none at the end
   initial begin
      @(negedge reset);
      repeat (3000) @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_stall <= 0;
            @(posedge clock);
         end else begin
            rsp_stall <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("inverse_albers_conic_projection_top: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed points: origin, extremes, zero easting, domain errors
      send_point(0, 0);
      send_point(0, 32'sd1000 * 256);
      send_point(0, -32'sd1000 * 256);
      send_point(32'sh7fffffff, 0);
      send_point(32'sh80000000, 0);
      send_point(32'sh7fffffff, 32'sh7fffffff);
      send_point(32'sh80000000, 32'sh80000000);
      send_point(32'sh80000000, 32'sh7fffffff);
      send_point(32'sh7fffffff, 32'sh80000000);
      send_point(-1, -1);
      send_point(1, 1);
      send_point(32'sd1000000 * 256, 32'sd2000000 * 256);
      send_point(-32'sd1500000 * 256, -32'sd2500000 * 256);
      send_point(32'sd3000000 * 256, 0);
      send_point(-32'sd2500000 * 256, 32'sd100);
      send_point(32'sd5000000 * 256, -32'sd3000000 * 256);
      send_point(32'sd8000000 * 256, 32'sd1);
      send_point(-32'sd8000000 * 256, 32'sd8000000 * 256);
      send_point(32'sh55555555, 32'shaaaaaaaa);
      send_point(32'shaaaaaaaa, 32'sh55555555);
      // Random points, calm at the end
      for (int i = 0; i < RANDOM_POINTS; i++) begin
         if (i == RANDOM_POINTS - QUIET_POINTS) quiet = 1;
         send_point(pick_coord(), pick_coord());
      end
      req_valid <= 0;
      while (open_points != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("inverse_albers_conic_projection_top: match");
      else
         $display("inverse_albers_conic_projection_top: mismatch");
      $finish;
   end

endmodule

[filelist.f]
src/iacp_pkg.sv
src/iacp_mul.sv
src/iacp_unit.sv
src/inverse_albers_conic_projection_top.sv
test/iacp_checker.sv
test/inverse_albers_conic_projection_top_tb.sv
